>>> rtl/core/frls_pkg.sv
`default_nettype none

package frls_pkg;

   localparam int SLOT_W        = 8;
   localparam int SLOTS_DEFAULT = 254;
   localparam int CUR_W         = 16;
   localparam int CRC_W         = 8;
   localparam int WORD_W        = 32;
   localparam int STAT_W        = 3;
   localparam int BYTE_W        = 8;

   // One pipeline stage per checked payload byte.
   localparam int CRC_STAGES = 3;

   localparam logic [CRC_W-1:0] CRC_POLY = 8'h07;
   localparam logic [CRC_W-1:0] CRC_INIT = 8'hFF;

   localparam int FLAG_LOCK_BIT = 0;
   localparam int FLAG_IDLE_BIT = 1;
   localparam int FLAG_DUAL_BIT = 2;

   typedef enum logic [STAT_W-1:0] {
      STAT_LOADED        = 3'd0,
      STAT_LOAD_INVALID  = 3'd1,
      STAT_SKIPPED       = 3'd2,
      STAT_SAVED         = 3'd3,
      STAT_ERASED_SAVED  = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SAVE,
      ST_SCAN,
      ST_OUT
   } state_type;

   // One record moving through the checksum pipeline.
   typedef struct packed {
      logic              valid;
      logic [SLOT_W-1:0] slot;
      logic [WORD_W-1:0] word;
      logic [CRC_W-1:0]  crc;
   } beat_type;

   // CRC-8 update over one byte, most significant bit first.
   function automatic logic [CRC_W-1:0] crc8_byte(input logic [CRC_W-1:0] crc_i,
                                                  input logic [BYTE_W-1:0] data_i);
      logic [CRC_W-1:0] c;
      c = crc_i ^ data_i;
      for (int k = 0; k < BYTE_W; k++) begin
         if (c[CRC_W-1]) begin
            c = {c[CRC_W-2:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[CRC_W-2:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

`default_nettype wire

>>> rtl/core/frls_crc_pipe.sv
`default_nettype none

// Three-stage CRC-8 pipeline: each stage folds one payload byte into the
// running checksum, so a new record can enter every cycle.
module frls_crc_pipe import frls_pkg::*; (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     flush,
   input  wire beat_type beat_in,
   output beat_type      beat_out
);

   beat_type stage_ff [CRC_STAGES];
   beat_type stage_in [CRC_STAGES];

   always_comb begin
      stage_in[0]     = beat_in;
      stage_in[0].crc = crc8_byte(CRC_INIT, beat_in.word[WORD_W-1 -: BYTE_W]);
      for (int k = 1; k < CRC_STAGES; k++) begin
         stage_in[k]     = stage_ff[k-1];
         stage_in[k].crc = crc8_byte(stage_ff[k-1].crc,
                                     stage_ff[k-1].word[WORD_W-1-BYTE_W*k -: BYTE_W]);
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < CRC_STAGES; k++) begin
         if (reset || flush) begin
            stage_ff[k] <= '0;
         end else begin
            stage_ff[k] <= stage_in[k];
         end
      end
   end

   assign beat_out = stage_ff[CRC_STAGES-1];

endmodule

`default_nettype wire

>>> rtl/core/flash_record_log_store.sv
`default_nettype none

// Channel   | Direction | Handshake            | Payload
// ----------+-----------+----------------------+------------------------------------------
// req_      | in        | req_valid/req_stall  | operation, ramp_current, flags, force_req
// rsp_      | out       | rsp_valid/rsp_stall  | status, found_*, slot, checksum
//
// A save's result passes through the checksum pipeline, then the step that
// decides and writes the record, then the result register.
// A load scans one slot per cycle through the read port and the checksum
// pipeline until the first failing slot, that one included, or the last
// slot; the single read port of the record memory sets that rate.
// Reset clears the control state. The write index doubles as a fill count:
// a slot at or above it reads as erased, so no clearing pass is run and an
// erase of the whole store is just a reset of the index.
// One item is in work at a time; a finished result waits in the output
// register while rsp_stall is high and the next request transfer is taken
// once the result has moved into that register.
module flash_record_log_store import frls_pkg::*; #(
   parameter int SLOTS = SLOTS_DEFAULT
) (
   input  wire logic              clock,
   input  wire logic              reset,

   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire logic              req_operation,
   input  wire logic [CUR_W-1:0]  req_ramp_current,
   input  wire logic              req_locked,
   input  wire logic              req_idle_led,
   input  wire logic              req_dual_cell,
   input  wire logic              req_force_req,

   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output logic [STAT_W-1:0]      rsp_status,
   output logic [CUR_W-1:0]       rsp_found_current,
   output logic                   rsp_found_locked,
   output logic                   rsp_found_idle_led,
   output logic                   rsp_found_dual_cell,
   output logic [SLOT_W-1:0]      rsp_slot,
   output logic [CRC_W-1:0]       rsp_checksum
);

   localparam int                ADDR_W    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam logic [SLOT_W-1:0] SLOTS_V   = SLOT_W'(SLOTS);
   localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(SLOTS - 1);

   // Record memory: one write port, one registered read port.
   logic [WORD_W-1:0] store_mem [SLOTS];

   state_type         state_ff, state_in;
   logic [SLOT_W-1:0] write_index_ff, write_index_in;
   logic [CRC_W-1:0]  last_crc_ff, last_crc_in;
   logic              save_force_ff, save_force_in;

   logic [SLOT_W-1:0] scan_addr_ff, scan_addr_in;
   logic              issuing_ff, issuing_in;
   logic              rd_issue_ff, rd_issue_in;
   logic              rd_hit_ff;
   logic [SLOT_W-1:0] rd_slot_ff;
   logic [WORD_W-1:0] rd_data_ff;

   logic              good_ff, good_in;
   logic [WORD_W-1:0] good_word_ff, good_word_in;
   logic [SLOT_W-1:0] good_slot_ff, good_slot_in;

   status_type        res_status_ff, res_status_in;
   logic [WORD_W-1:0] res_word_ff, res_word_in;
   logic [SLOT_W-1:0] res_slot_ff, res_slot_in;
   logic [CRC_W-1:0]  res_crc_ff, res_crc_in;
   logic              res_found_ff, res_found_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [STAT_W-1:0] rsp_status_ff;
   logic [CUR_W-1:0]  rsp_current_ff;
   logic              rsp_locked_ff, rsp_idle_ff, rsp_dual_ff;
   logic [SLOT_W-1:0] rsp_slot_ff;
   logic [CRC_W-1:0]  rsp_crc_ff;

   logic              accept;
   logic              scan_issue;
   logic              scan_done;
   logic              save_done;
   logic              flush;
   logic              out_load;
   logic              pipe_good;
   logic              mem_we;
   logic [SLOT_W-1:0] mem_waddr;
   logic [WORD_W-1:0] mem_wdata;
   logic [WORD_W-1:0] save_word;
   logic              save_skip;
   logic              save_erase;
   logic [SLOT_W-1:0] save_index;
   beat_type          pipe_in;
   beat_type          pipe_out;

   frls_crc_pipe u_crc_pipe (
      .clock    (clock),
      .reset    (reset),
      .flush    (flush),
      .beat_in  (pipe_in),
      .beat_out (pipe_out)
   );

   assign accept    = req_valid && (state_ff == ST_IDLE);
   assign req_stall = (state_ff != ST_IDLE);
   assign pipe_good = (pipe_out.crc == pipe_out.word[CRC_W-1:0]);
   assign out_load  = (state_ff == ST_OUT) && (!rsp_valid_ff || !rsp_stall);

   assign save_word = {req_ramp_current, 5'b00000, req_dual_cell, req_idle_led,
                       req_locked, {CRC_W{1'b0}}};

   assign save_skip  = !save_force_ff && (pipe_out.crc == last_crc_ff);
   assign save_erase = save_force_ff || (write_index_ff >= SLOTS_V);
   assign save_index = save_erase ? '0 : write_index_ff;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = req_operation ? ST_SAVE : ST_SCAN;
            end
         end
         ST_SAVE: begin
            if (pipe_out.valid) begin
               state_in = ST_OUT;
            end
         end
         ST_SCAN: begin
            if (pipe_out.valid && (!pipe_good || pipe_out.slot == LAST_SLOT)) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Control outputs of the sequencer.
   always_comb begin
      scan_issue = 1'b0;
      scan_done  = 1'b0;
      save_done  = 1'b0;
      mem_we     = 1'b0;
      mem_waddr  = save_index;
      mem_wdata  = {pipe_out.word[WORD_W-1:CRC_W], pipe_out.crc};

      // The checksum pipeline carries either the record being saved or the
      // word registered at the output of the read port.
      pipe_in.valid = rd_issue_ff;
      pipe_in.slot  = rd_slot_ff;
      pipe_in.word  = rd_hit_ff ? rd_data_ff : '1;
      pipe_in.crc   = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept && req_operation) begin
               pipe_in.valid = 1'b1;
               pipe_in.slot  = '0;
               pipe_in.word  = save_word;
            end
         end
         ST_SAVE: begin
            save_done = pipe_out.valid;
            mem_we    = pipe_out.valid && !save_skip;
         end
         ST_SCAN: begin
            scan_issue = issuing_ff;
            scan_done  = pipe_out.valid && (!pipe_good || pipe_out.slot == LAST_SLOT);
         end
         ST_OUT: begin
         end
         default: begin
         end
      endcase
   end

   // Scan and result bookkeeping.
   always_comb begin
      write_index_in = write_index_ff;
      last_crc_in    = last_crc_ff;
      save_force_in  = save_force_ff;
      scan_addr_in   = scan_addr_ff;
      issuing_in     = issuing_ff;
      good_in        = good_ff;
      good_word_in   = good_word_ff;
      good_slot_in   = good_slot_ff;
      res_status_in  = res_status_ff;
      res_word_in    = res_word_ff;
      res_slot_in    = res_slot_ff;
      res_crc_in     = res_crc_ff;
      res_found_in   = res_found_ff;

      if (accept) begin
         save_force_in = req_force_req;
         scan_addr_in  = '0;
         issuing_in    = !req_operation;
         good_in       = 1'b0;
      end

      if (scan_issue) begin
         scan_addr_in = scan_addr_ff + 1'b1;
         if (scan_addr_ff == LAST_SLOT) begin
            issuing_in = 1'b0;
         end
      end

      if ((state_ff == ST_SCAN) && pipe_out.valid && pipe_good) begin
         good_in      = 1'b1;
         good_word_in = pipe_out.word;
         good_slot_in = pipe_out.slot;
      end

      if (scan_done) begin
         issuing_in   = 1'b0;
         res_found_in = 1'b1;
         if (pipe_good) begin
            // Every slot checked out; the last one is the answer.
            res_status_in  = STAT_LOADED;
            res_word_in    = pipe_out.word;
            res_slot_in    = pipe_out.slot;
            res_crc_in     = pipe_out.word[CRC_W-1:0];
            last_crc_in    = pipe_out.word[CRC_W-1:0];
            write_index_in = pipe_out.slot + 1'b1;
         end else if (good_ff) begin
            res_status_in  = STAT_LOADED;
            res_word_in    = good_word_ff;
            res_slot_in    = good_slot_ff;
            res_crc_in     = good_word_ff[CRC_W-1:0];
            last_crc_in    = good_word_ff[CRC_W-1:0];
            write_index_in = good_slot_ff + 1'b1;
         end else begin
            res_status_in  = STAT_LOAD_INVALID;
            res_found_in   = 1'b0;
            res_slot_in    = '0;
            res_crc_in     = '0;
            write_index_in = '0;
         end
      end

      if (save_done) begin
         res_found_in = 1'b0;
         res_crc_in   = pipe_out.crc;
         if (save_skip) begin
            res_status_in = STAT_SKIPPED;
            res_slot_in   = '0;
         end else begin
            res_status_in  = save_erase ? STAT_ERASED_SAVED : STAT_SAVED;
            res_slot_in    = save_index;
            write_index_in = save_index + 1'b1;
            last_crc_in    = pipe_out.crc;
         end
      end
   end

   assign flush        = scan_done;
   assign rd_issue_in  = scan_issue && !flush;
   assign rsp_valid_in = (state_ff == ST_OUT) ? 1'b1 : (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         write_index_ff <= '0;
         last_crc_ff    <= '0;
         issuing_ff     <= 1'b0;
         rd_issue_ff    <= 1'b0;
         good_ff        <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         write_index_ff <= write_index_in;
         last_crc_ff    <= last_crc_in;
         issuing_ff     <= issuing_in;
         rd_issue_ff    <= rd_issue_in;
         good_ff        <= good_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      save_force_ff <= save_force_in;
      scan_addr_ff  <= scan_addr_in;
      rd_slot_ff    <= scan_addr_ff;
      rd_hit_ff     <= (scan_addr_ff < write_index_ff);
      good_word_ff  <= good_word_in;
      good_slot_ff  <= good_slot_in;
      res_status_ff <= res_status_in;
      res_word_ff   <= res_word_in;
      res_slot_ff   <= res_slot_in;
      res_crc_ff    <= res_crc_in;
      res_found_ff  <= res_found_in;
      if (out_load) begin
         rsp_status_ff  <= res_status_ff;
         rsp_current_ff <= res_found_ff ? res_word_ff[WORD_W-1 -: CUR_W] : '0;
         rsp_locked_ff  <= res_found_ff && res_word_ff[BYTE_W + FLAG_LOCK_BIT];
         rsp_idle_ff    <= res_found_ff && res_word_ff[BYTE_W + FLAG_IDLE_BIT];
         rsp_dual_ff    <= res_found_ff && res_word_ff[BYTE_W + FLAG_DUAL_BIT];
         rsp_slot_ff    <= res_slot_ff;
         rsp_crc_ff     <= res_crc_ff;
      end
   end

   // Record memory. Saves and scans never overlap, so the read port needs
   // no forwarding from the write port.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         store_mem[mem_waddr[ADDR_W-1:0]] <= mem_wdata;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= store_mem[scan_addr_ff[ADDR_W-1:0]];
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_status          = rsp_status_ff;
   assign rsp_found_current   = rsp_current_ff;
   assign rsp_found_locked    = rsp_locked_ff;
   assign rsp_found_idle_led  = rsp_idle_ff;
   assign rsp_found_dual_cell = rsp_dual_ff;
   assign rsp_slot            = rsp_slot_ff;
   assign rsp_checksum        = rsp_crc_ff;

   // The fill count never passes the number of slots.
   a_index_range: assert property (@(posedge clock) disable iff (reset)
      write_index_ff <= SLOTS_V)
      else $error("write index beyond the store");

   // The checksum pipeline is empty whenever the sequencer is idle.
   a_pipe_empty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !pipe_out.valid)
      else $error("stale record left in checksum pipeline");

   // A written record leaves the fill count nonzero and becomes the last checksum.
   a_write_update: assert property (@(posedge clock) disable iff (reset)
      mem_we |=> (write_index_ff != '0) && (last_crc_ff == $past(mem_wdata[CRC_W-1:0])))
      else $error("record write did not update index and checksum");

   // The scan never reads past the last slot.
   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      scan_issue |-> (scan_addr_ff < SLOTS_V))
      else $error("scan address beyond the store");

endmodule

`default_nettype wire
